>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the pitch and tilt alarm block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define APTA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define APTA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/apta_pkg.sv
// ----------------------------------------------------------------------------
// apta_pkg
// Widths, constants and types shared by the pitch and tilt alarm pipeline.
// ----------------------------------------------------------------------------
package apta_pkg;

  // Raw sample and squared magnitude
  localparam int RawW  = 16;
  localparam int SqW   = 32;

  // Square root: one result bit per stage
  localparam int RootW     = 32;
  localparam int RemW      = RootW + 2;
  localparam int SqrtSteps = RootW;

  // Normalisation of the CORDIC operands
  localparam int NormW          = 41;
  localparam int NormStages     = 3;
  localparam int NormFirstShift = 32;
  localparam int FracBits       = 16;

  // CORDIC datapath
  localparam int CordicSteps = 23;
  localparam int CW          = 45;
  localparam int AccW        = 25;
  localparam int AtanW       = 22;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  localparam logic [AtanW-1:0] AtanTab [CordicSteps] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1
  };

  // Degrees and output
  localparam int DegW   = 7;
  localparam int PitchW = 9;
  localparam logic [DegW-1:0] DegZero  = 7'd0;
  localparam logic [DegW-1:0] DegRight = 7'd90;
  localparam logic [DegW-1:0] DegHalf  = 7'd45;
  localparam logic [DegW-1:0] DegClamp = 7'd89;
  localparam logic signed [9:0] PitchMax = 10'sd180;
  localparam logic signed [9:0] PitchMin = -10'sd180;

  // Configuration registers
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgAngleOffset = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTiltLimit   = CfgIdxW'(1);
  localparam logic signed [7:0]  OffsetReset    = -8'sd41;
  localparam logic [7:0]         LimitReset     = 8'd30;

  // Output skid buffer
  localparam int SkidDepth = 2;
  localparam int SkidPtrW  = $clog2(SkidDepth);
  localparam int SkidCntW  = $clog2(SkidDepth + 1);

  // Per-sample facts carried alongside the datapath
  typedef struct packed {
    logic [RawW-1:0] abs_y;
    logic            neg;
    logic            y_zero;
    logic            s_zero;
    logic            equal;
  } meta_t;

  typedef struct packed {
    logic              tilt_alarm;
    logic [PitchW-1:0] pitch_degrees;
  } out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } skid_stat_t;

endpackage

>>> src/apta_sqrt.sv
// ----------------------------------------------------------------------------
// apta_sqrt
// Pipelined digit-by-digit square root of s * 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module apta_sqrt
  import apta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SqW-1:0]   in_s,
  input  meta_t            in_meta,
  output logic             out_valid,
  output logic [RootW-1:0] out_root,
  output meta_t            out_meta
);

  logic             vld    [SqrtSteps];
  logic [SqW-1:0]   s_r    [SqrtSteps];
  logic [RemW-1:0]  rem_r  [SqrtSteps];
  logic [RootW-1:0] root_r [SqrtSteps];
  meta_t            meta_r [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    logic             v_in;
    logic [SqW-1:0]   s_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    meta_t            m_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             fits;

    if (j == 0) begin : g_head
      assign v_in    = in_valid;
      assign s_in    = in_s;
      assign rem_in  = '0;
      assign root_in = '0;
      assign m_in    = in_meta;
    end else begin : g_body
      assign v_in    = vld[j-1];
      assign s_in    = s_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign m_in    = meta_r[j-1];
    end

    // s moves up two bits a stage; once it is spent the low radicand zeros follow
    assign rem_sh = {rem_in[RemW-3:0], s_in[SqW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j]    <= {s_in[SqW-3:0], 2'b00};
        rem_r[j]  <= fits ? (rem_sh - trial) : rem_sh;
        root_r[j] <= {root_in[RootW-2:0], fits};
        meta_r[j] <= m_in;
      end
    end
  end

  assign out_valid = vld[SqrtSteps-1];
  assign out_root  = root_r[SqrtSteps-1];
  assign out_meta  = meta_r[SqrtSteps-1];

endmodule

>>> src/apta_norm.sv
// ----------------------------------------------------------------------------
// apta_norm
// Shift both CORDIC operands left together until the larger reaches bit 40.
// ----------------------------------------------------------------------------
module apta_norm
  import apta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RootW-1:0] in_root,
  input  meta_t            in_meta,
  output logic             out_valid,
  output logic [NormW-1:0] out_a,
  output logic [NormW-1:0] out_b,
  output meta_t            out_meta
);

  logic             vld    [NormStages];
  logic [NormW-1:0] a_r    [NormStages];
  logic [NormW-1:0] b_r    [NormStages];
  meta_t            meta_r [NormStages];

  for (genvar k = 0; k < NormStages; k++) begin : g_stage
    localparam int ShHi = NormFirstShift >> (2 * k);
    localparam int ShLo = NormFirstShift >> (2 * k + 1);

    logic             v_in;
    logic [NormW-1:0] a_in;
    logic [NormW-1:0] b_in;
    meta_t            m_in;
    logic [NormW-1:0] a_mid;
    logic [NormW-1:0] b_mid;
    logic [NormW-1:0] a_out;
    logic [NormW-1:0] b_out;

    if (k == 0) begin : g_head
      assign v_in = in_valid;
      assign a_in = NormW'(in_root);
      assign b_in = NormW'({in_meta.abs_y, {FracBits{1'b0}}});
      assign m_in = in_meta;
    end else begin : g_body
      assign v_in = vld[k-1];
      assign a_in = a_r[k-1];
      assign b_in = b_r[k-1];
      assign m_in = meta_r[k-1];
    end

    // two binary steps of the leading-zero shift per stage
    always_comb begin
      if (((a_in | b_in) >> (NormW - ShHi)) == '0) begin
        a_mid = a_in << ShHi;
        b_mid = b_in << ShHi;
      end else begin
        a_mid = a_in;
        b_mid = b_in;
      end
      if (((a_mid | b_mid) >> (NormW - ShLo)) == '0) begin
        a_out = a_mid << ShLo;
        b_out = b_mid << ShLo;
      end else begin
        a_out = a_mid;
        b_out = b_mid;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]    <= a_out;
        b_r[k]    <= b_out;
        meta_r[k] <= m_in;
      end
    end
  end

  assign out_valid = vld[NormStages-1];
  assign out_a     = a_r[NormStages-1];
  assign out_b     = b_r[NormStages-1];
  assign out_meta  = meta_r[NormStages-1];

endmodule

>>> src/apta_cordic.sv
// ----------------------------------------------------------------------------
// apta_cordic
// Vectoring CORDIC, one micro-rotation per stage, angle accumulated in Q.16 degrees.
// ----------------------------------------------------------------------------
module apta_cordic
  import apta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NormW-1:0]       in_a,
  input  logic [NormW-1:0]       in_b,
  input  meta_t                  in_meta,
  output logic                   out_valid,
  output logic signed [AccW-1:0] out_acc,
  output meta_t                  out_meta
);

  logic                   vld    [CordicSteps];
  logic signed [CW-1:0]   cx_r   [CordicSteps];
  logic signed [CW-1:0]   cy_r   [CordicSteps];
  logic signed [AccW-1:0] acc_r  [CordicSteps];
  meta_t                  meta_r [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
    logic                   v_in;
    logic signed [CW-1:0]   cx_in;
    logic signed [CW-1:0]   cy_in;
    logic signed [AccW-1:0] acc_in;
    meta_t                  m_in;
    logic signed [AccW-1:0] ang;
    logic signed [CW-1:0]   cx_sh;
    logic signed [CW-1:0]   cy_sh;

    if (i == 0) begin : g_head
      assign v_in   = in_valid;
      assign cx_in  = $signed(CW'(in_a));
      assign cy_in  = $signed(CW'(in_b));
      assign acc_in = '0;
      assign m_in   = in_meta;
    end else begin : g_body
      assign v_in   = vld[i-1];
      assign cx_in  = cx_r[i-1];
      assign cy_in  = cy_r[i-1];
      assign acc_in = acc_r[i-1];
      assign m_in   = meta_r[i-1];
    end

    assign ang   = $signed(AccW'(AtanTab[i]));
    assign cx_sh = cx_in >>> i;
    assign cy_sh = cy_in >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    // rotate towards y = 0, both updates from the old values
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_in[CW-1]) begin
          cx_r[i]  <= cx_in + cy_sh;
          cy_r[i]  <= cy_in - cx_sh;
          acc_r[i] <= acc_in + ang;
        end else begin
          cx_r[i]  <= cx_in - cy_sh;
          cy_r[i]  <= cy_in + cx_sh;
          acc_r[i] <= acc_in - ang;
        end
        meta_r[i] <= m_in;
      end
    end
  end

  assign out_valid = vld[CordicSteps-1];
  assign out_acc   = acc_r[CordicSteps-1];
  assign out_meta  = meta_r[CordicSteps-1];

endmodule

>>> src/apta_skid.sv
// ----------------------------------------------------------------------------
// apta_skid
// Two-entry result buffer between the pipeline and the output stream.
// ----------------------------------------------------------------------------
module apta_skid
  import apta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_t       push_data,
  input  logic       pop_ready,
  output logic       pop_valid,
  output out_t       pop_data,
  output skid_stat_t stat
);

  out_t                entry [SkidDepth];
  logic [SkidPtrW-1:0] wr_ptr;
  logic [SkidPtrW-1:0] rd_ptr;
  logic [SkidCntW-1:0] count;
  logic                pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == SkidCntW'(SkidDepth));
  assign pop        = !stat.empty && pop_ready;
  assign pop_valid  = !stat.empty;
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + SkidPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + SkidPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + SkidCntW'(1);
        2'b01:   count <= count - SkidCntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/accel_pitch_tilt_alarm.sv
// ----------------------------------------------------------------------------
// accel_pitch_tilt_alarm
// Pitch angle in whole degrees and a tilt alarm from three-axis samples.
//
// Input stream s_axis: one beat per sample, raw x, y, z. Output stream m_axis:
// one beat per sample, corrected pitch and alarm bit, in input order.
// Config channel cfg_*: index 0 writes angle_offset, index 1 tilt_limit; other
// indexes are ignored. Write only while no sample is in flight.
// Pipeline: a result passes 63 pipeline registers after its input beat (3
// front, 32 square-root bit stages, 3 normalise, 23 CORDIC, 2 finish), then the
// output buffer. Throughput: one sample per cycle while the pipeline is not
// held, set by the fully pipelined square root and CORDIC.
// Reset clears every valid bit and loads offset -41, limit 30.
// When the receiver stalls, up to two results wait in the output buffer while
// the pipeline keeps taking samples; with the buffer full and a result at the
// end of the pipeline, the whole pipeline holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_pitch_tilt_alarm
  import apta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // s_axis_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,
  // m_axis_tdata: pitch_degrees [8:0], tilt_alarm [9], zeros [15:10]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  logic              en;
  skid_stat_t        skid_stat;

  logic signed [7:0] angle_offset;
  logic [7:0]        tilt_limit;

  // ---- configuration: always ready, takes effect on results entering finish 2 after the write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= OffsetReset;
      tilt_limit   <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgAngleOffset: angle_offset <= $signed(cfg_data);
        CfgTiltLimit:   tilt_limit   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // ---- front: register the sample
  logic                   p1_valid;
  logic signed [RawW-1:0] p1_x;
  logic signed [RawW-1:0] p1_y;
  logic signed [RawW-1:0] p1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x <= $signed(s_axis_tdata[15:0]);
      p1_y <= $signed(s_axis_tdata[31:16]);
      p1_z <= $signed(s_axis_tdata[47:32]);
    end
  end

  // ---- front: squares and |y|
  logic signed [SqW-1:0] xx_c;
  logic signed [SqW-1:0] yy_c;
  logic signed [SqW-1:0] zz_c;
  logic [RawW-1:0]       abs_y_c;
  logic                  p2_valid;
  logic [SqW-2:0]        p2_xx;
  logic [SqW-2:0]        p2_yy;
  logic [SqW-2:0]        p2_zz;
  meta_t                 p2_meta;

  assign xx_c    = SqW'(p1_x) * SqW'(p1_x);
  assign yy_c    = SqW'(p1_y) * SqW'(p1_y);
  assign zz_c    = SqW'(p1_z) * SqW'(p1_z);
  // -(-32768) wraps to 16'h8000, which is right as an unsigned magnitude
  assign abs_y_c = p1_y[RawW-1] ? RawW'(-p1_y) : RawW'(p1_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_xx          <= xx_c[SqW-2:0];
      p2_yy          <= yy_c[SqW-2:0];
      p2_zz          <= zz_c[SqW-2:0];
      p2_meta.abs_y  <= abs_y_c;
      p2_meta.neg    <= p1_y[RawW-1];
      p2_meta.y_zero <= (p1_y == '0);
      p2_meta.s_zero <= 1'b0;
      p2_meta.equal  <= 1'b0;
    end
  end

  // ---- front: x*x + z*z and the special-case flags
  logic [SqW-1:0] s_c;
  meta_t          meta_c;
  logic           p3_valid;
  logic [SqW-1:0] p3_s;
  meta_t          p3_meta;

  assign s_c = {1'b0, p2_xx} + {1'b0, p2_zz};

  always_comb begin
    meta_c        = p2_meta;
    meta_c.s_zero = (s_c == '0);
    meta_c.equal  = ({1'b0, p2_yy} == s_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_s    <= s_c;
      p3_meta <= meta_c;
    end
  end

  // ---- square root, normalise, CORDIC
  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  meta_t            sq_meta;

  apta_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_valid),
    .in_s      (p3_s),
    .in_meta   (p3_meta),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_meta  (sq_meta)
  );

  logic             nm_valid;
  logic [NormW-1:0] nm_a;
  logic [NormW-1:0] nm_b;
  meta_t            nm_meta;

  apta_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_meta   (sq_meta),
    .out_valid (nm_valid),
    .out_a     (nm_a),
    .out_b     (nm_b),
    .out_meta  (nm_meta)
  );

  logic                   cd_valid;
  logic signed [AccW-1:0] cd_acc;
  meta_t                  cd_meta;

  apta_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (nm_valid),
    .in_a      (nm_a),
    .in_b      (nm_b),
    .in_meta   (nm_meta),
    .out_valid (cd_valid),
    .out_acc   (cd_acc),
    .out_meta  (cd_meta)
  );

  // ---- finish 1: whole degrees, special cases, sign of y
  logic [7:0]        acc_whole;
  logic [DegW-1:0]   acc_deg;
  logic [DegW-1:0]   deg_c;
  logic signed [7:0] spitch_c;
  logic              f1_valid;
  logic signed [7:0] f1_pitch;

  always_comb begin
    // a negative angle sum counts as zero; keep the integer part, at most 89
    acc_whole = cd_acc[AccW-1] ? '0 : cd_acc[AccW-2:FracBits];
    acc_deg   = (acc_whole > {1'b0, DegClamp}) ? DegClamp : acc_whole[DegW-1:0];
    priority if (cd_meta.y_zero) begin
      deg_c = DegZero;
    end else if (cd_meta.s_zero) begin
      deg_c = DegRight;
    end else if (cd_meta.equal) begin
      deg_c = DegHalf;
    end else begin
      deg_c = acc_deg;
    end
    spitch_c = cd_meta.neg ? -$signed({1'b0, deg_c}) : $signed({1'b0, deg_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_pitch <= spitch_c;
    end
  end

  // ---- finish 2: offset, saturate to +/-180, alarm
  logic signed [9:0] diff_c;
  logic signed [9:0] pitch_w;
  logic signed [9:0] lim_w;
  out_t              res_c;
  logic              f2_valid;
  out_t              f2_res;

  always_comb begin
    diff_c = {{2{f1_pitch[7]}}, f1_pitch} - {{2{angle_offset[7]}}, angle_offset};
    priority if (diff_c > PitchMax) begin
      pitch_w = PitchMax;
    end else if (diff_c < PitchMin) begin
      pitch_w = PitchMin;
    end else begin
      pitch_w = diff_c;
    end
    // a zero limit makes the alarm unconditional, as one of the two compares then always holds
    lim_w               = $signed({2'b00, tilt_limit});
    res_c.pitch_degrees = pitch_w[PitchW-1:0];
    res_c.tilt_alarm    = (pitch_w >= lim_w) || (pitch_w <= -lim_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_res <= res_c;
    end
  end

  // ---- output buffer and pipeline advance
  out_t m_res;

  // hold everything only when a finished result has nowhere to go
  assign en            = !(f2_valid && skid_stat.full);
  assign s_axis_tready = en;

  apta_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (f2_valid && en),
    .push_data (f2_res),
    .pop_ready (m_axis_tready),
    .pop_valid (m_axis_tvalid),
    .pop_data  (m_res),
    .stat      (skid_stat)
  );

  assign m_axis_tdata = {6'b000000, m_res};

  // ---- checks
  `APTA_ASSERT_IMP(a_pitch_range, clk, rst, m_axis_tvalid, ($signed(m_axis_tdata[8:0]) >= -180) && ($signed(m_axis_tdata[8:0]) <= 180), "pitch beyond +/-180")
  `APTA_ASSERT_IMP(a_zero_limit, clk, rst, m_axis_tvalid && (tilt_limit == '0), m_axis_tdata[9], "alarm clear with zero limit")
  `APTA_ASSERT_IMP(a_deg_range, clk, rst, f1_valid, (f1_pitch >= -90) && (f1_pitch <= 90), "raw pitch beyond +/-90")
  `APTA_ASSERT_IMP(a_stall_cause, clk, rst, !s_axis_tready, m_axis_tvalid && skid_stat.full, "input held without full buffer")
  `APTA_ASSERT_NXT(a_stall_keep, clk, rst, f2_valid && !en, f2_valid, "held result dropped")

endmodule
